### src/aca_pkg.sv
// ----------------------------------------------------------------------------
// aca_pkg: shared types and constants
// Operation codes, controller states and the command/status bundles that
// join the controller and the datapath of the argmax confusion accumulator.
// ----------------------------------------------------------------------------
package aca_pkg;

	localparam int CLASS_W   = 5;
	localparam int VALUE_W   = 32;
	localparam int CNT_OUT_W = 16;

	typedef enum logic [1:0] {
		OP_SCORE = 2'd0,
		OP_PRIOR = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic KIND_PRED = 1'b0;
	localparam logic KIND_CELL = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRIOR_RD,
		ST_MUL,
		ST_CMP,
		ST_CELL_RD,
		ST_CELL_UPD,
		ST_READ_OUT,
		ST_PRIOR_WR
	} state_t;

	typedef struct packed {
		logic capture;
		logic prior_rd;
		logic mul;
		logic cmp;
		logic cell_rd;
		logic cell_upd;
		logic rd_out;
		logic prior_wr;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic [1:0] op;
		logic       last;
		logic       out_free;
		logic       clr_last;
	} status_t;

endpackage

### src/aca_in_if.sv
// ----------------------------------------------------------------------------
// aca_in_if: input item channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface aca_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [4:0]  class_index;
	logic [4:0]  true_label;
	logic [31:0] value;
	logic        last_class;

	modport source (output valid, operation, class_index, true_label, value, last_class,
		input ready);
	modport sink (input valid, operation, class_index, true_label, value, last_class,
		output ready);
endinterface

### src/aca_out_if.sv
// ----------------------------------------------------------------------------
// aca_out_if: result channel
// Valid/ready channel carrying one prediction or cell read result.
// ----------------------------------------------------------------------------
interface aca_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [4:0]  predicted_class;
	logic [15:0] cell_count;

	modport source (output valid, result_kind, predicted_class, cell_count, input ready);
	modport sink (input valid, result_kind, predicted_class, cell_count, output ready);
endinterface

### src/aca_ctrl.sv
// ----------------------------------------------------------------------------
// aca_ctrl: sequencing controller
// Walks each accepted item through prior read, multiply, compare, cell
// read/update/out, prior write or the matrix clear, issuing datapath commands.
// ----------------------------------------------------------------------------
module aca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  aca_pkg::status_t  status,
	output aca_pkg::cmd_t     cmd
);

	aca_pkg::state_t state_q;
	aca_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aca_pkg::ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			aca_pkg::ST_CLEAR: begin
				if (status.clr_last) begin
					state_next = aca_pkg::ST_IDLE;
				end
			end
			aca_pkg::ST_IDLE: begin
				if (item_valid) begin
					unique case (status.in_op)
						aca_pkg::OP_SCORE: state_next = aca_pkg::ST_PRIOR_RD;
						aca_pkg::OP_PRIOR: state_next = aca_pkg::ST_PRIOR_WR;
						aca_pkg::OP_READ:  state_next = aca_pkg::ST_CELL_RD;
						default:           state_next = aca_pkg::ST_CLEAR;
					endcase
				end
			end
			aca_pkg::ST_PRIOR_RD: state_next = aca_pkg::ST_MUL;
			aca_pkg::ST_MUL:      state_next = aca_pkg::ST_CMP;
			aca_pkg::ST_CMP: begin
				state_next = status.last ? aca_pkg::ST_CELL_RD : aca_pkg::ST_IDLE;
			end
			aca_pkg::ST_CELL_RD: begin
				state_next = (status.op == aca_pkg::OP_SCORE) ? aca_pkg::ST_CELL_UPD
					: aca_pkg::ST_READ_OUT;
			end
			aca_pkg::ST_CELL_UPD, aca_pkg::ST_READ_OUT: begin
				if (status.out_free) begin
					state_next = aca_pkg::ST_IDLE;
				end
			end
			aca_pkg::ST_PRIOR_WR: state_next = aca_pkg::ST_IDLE;
			default:              state_next = aca_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			aca_pkg::ST_CLEAR:    cmd.clr_wr = 1'b1;
			aca_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			aca_pkg::ST_PRIOR_RD: cmd.prior_rd = 1'b1;
			aca_pkg::ST_MUL:      cmd.mul = 1'b1;
			aca_pkg::ST_CMP:      cmd.cmp = 1'b1;
			aca_pkg::ST_CELL_RD:  cmd.cell_rd = 1'b1;
			// hold until the output register can take the result
			aca_pkg::ST_CELL_UPD: cmd.cell_upd = status.out_free;
			aca_pkg::ST_READ_OUT: cmd.rd_out = status.out_free;
			aca_pkg::ST_PRIOR_WR: cmd.prior_wr = 1'b1;
			default:              cmd = '0;
		endcase
	end

endmodule

### src/aca_dp.sv
// ----------------------------------------------------------------------------
// aca_dp: accumulator datapath
// Item latch, prior memory with valid bits, score-by-prior multiplier, running
// best, confusion counter memory with saturating update, and output register.
// ----------------------------------------------------------------------------
module aca_dp #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aca_pkg::cmd_t     cmd,
	output aca_pkg::status_t  status,
	input  logic [4:0]        num_classes,
	input  logic [1:0]        in_operation,
	input  logic [4:0]        in_class_index,
	input  logic [4:0]        in_true_label,
	input  logic [31:0]       in_value,
	input  logic              in_last_class,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              res_kind,
	output logic [4:0]        res_predicted_class,
	output logic [15:0]       res_cell_count
);

	localparam int SIDE   = MAX_CLASSES + 1;
	localparam int DEPTH  = SIDE * SIDE;
	localparam int PIDX_W = $clog2(SIDE);
	localparam int AW     = $clog2(DEPTH);
	localparam logic [6:0]    MAXC      = 7'(MAX_CLASSES);
	localparam logic [13:0]   SIDE_C    = 14'(SIDE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// latched item
	logic [1:0]  op_q;
	logic [4:0]  cls_q;
	logic [4:0]  lab_q;
	logic [31:0] val_q;
	logic        last_q;
	logic        in_use_q;

	logic [31:0] pmem [SIDE];
	logic [SIDE-1:0] pvalid_q;
	logic [31:0] prior_s1;
	logic        pvld_s1;
	logic [63:0] prod_s2;

	logic [63:0] best_score_q;
	logic [4:0]  best_class_q;

	logic [COUNT_WIDTH-1:0] cmem [DEPTH];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [AW-1:0]          clr_q;

	logic        res_valid_q;
	logic        res_kind_q;
	logic [4:0]  res_pred_q;
	logic [15:0] res_count_q;

	logic [6:0]  cls_ext;
	logic [6:0]  lab_ext;
	logic [PIDX_W-1:0] pidx;
	logic        in_use;
	logic        lab_ok;
	logic        rd_ok;
	logic [4:0]  col;
	logic [13:0] addr_full;
	logic [AW-1:0] cell_addr;
	logic [31:0] prior_eff;
	logic [COUNT_WIDTH-1:0] inc;
	logic [31:0] inc_ext;
	logic [31:0] rd_ext;
	logic        out_free;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;

	assign cls_ext = {2'b00, cls_q};
	assign lab_ext = {2'b00, lab_q};
	assign pidx    = cls_ext[PIDX_W-1:0];
	assign in_use  = (in_class_index != 5'd0) && (in_class_index <= num_classes)
		&& ({2'b00, in_class_index} <= MAXC);
	assign lab_ok  = (lab_ext <= MAXC);
	assign rd_ok   = lab_ok && (cls_ext <= MAXC);

	assign col       = (op_q == aca_pkg::OP_SCORE) ? best_class_q : cls_q;
	assign addr_full = {9'd0, lab_q} * SIDE_C + {9'd0, col};
	assign cell_addr = addr_full[AW-1:0];

	assign prior_eff = pvld_s1 ? prior_s1 : 32'd0;
	assign inc       = (&rdata_q) ? rdata_q : rdata_q + COUNT_WIDTH'(1);
	assign inc_ext   = 32'(inc);
	assign rd_ext    = 32'(rdata_q);
	assign out_free  = !res_valid_q || res_ready;

	assign mem_we    = cmd.clr_wr || (cmd.cell_upd && lab_ok);
	assign mem_waddr = cmd.clr_wr ? clr_q : cell_addr;
	assign mem_wdata = cmd.clr_wr ? '0 : inc;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_operation;
			cls_q    <= in_class_index;
			lab_q    <= in_true_label;
			val_q    <= in_value;
			last_q   <= in_last_class;
			in_use_q <= in_use;
		end
	end

	// prior memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.prior_wr && (cls_ext <= MAXC)) begin
			pmem[pidx] <= val_q;
		end
		if (cmd.prior_rd) begin
			prior_s1 <= pmem[pidx];
			pvld_s1  <= pvalid_q[pidx];
		end
		if (cmd.mul) begin
			prod_s2 <= 64'(val_q) * 64'(prior_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (cmd.prior_wr && (cls_ext <= MAXC)) begin
			pvalid_q[pidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
		end else if (cmd.cell_upd) begin
			best_score_q <= '0;
			best_class_q <= '0;
		end else if (cmd.cmp && in_use_q && (prod_s2 > best_score_q)) begin
			best_score_q <= prod_s2;
			best_class_q <= cls_q;
		end
	end

	// confusion memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cmem[mem_waddr] <= mem_wdata;
		end
		if (cmd.cell_rd) begin
			rdata_q <= cmem[cell_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.cell_upd || cmd.rd_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cell_upd) begin
			res_kind_q  <= aca_pkg::KIND_PRED;
			res_pred_q  <= best_class_q;
			res_count_q <= lab_ok ? inc_ext[15:0] : 16'd0;
		end else if (cmd.rd_out) begin
			res_kind_q  <= aca_pkg::KIND_CELL;
			res_pred_q  <= cls_q;
			res_count_q <= rd_ok ? rd_ext[15:0] : 16'd0;
		end
	end

	assign res_valid           = res_valid_q;
	assign res_kind            = res_kind_q;
	assign res_predicted_class = res_pred_q;
	assign res_cell_count      = res_count_q;

	assign status.in_op    = in_operation;
	assign status.op       = op_q;
	assign status.last     = last_q;
	assign status.out_free = out_free;
	assign status.clr_last = (clr_q == LAST_ADDR);

endmodule

### src/argmax_confusion_accumulator_core.sv
// A score item that does not end a node steps through accept, prior read, multiply
// and compare; a node's last score goes on to cell read and the cell update that
// registers its prediction; a cell read: accept, cell read, read-out; a prior write:
// accept, prior write; a clear: accept and a sweep of all (MAX_CLASSES+1)^2 cells.
// The next item is accepted only back in idle; a result waits for a free output
// register. Reset clears control, prior valid bits and best, then runs the sweep.
// ----------------------------------------------------------------------------
// argmax_confusion_accumulator_core: top level
// Weighted argmax per node with a saturating confusion matrix; APB register
// for the number of classes in use.
// ----------------------------------------------------------------------------
module argmax_confusion_accumulator_core #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	aca_in_if.sink      item,
	aca_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// classes above 31 cannot be named by a 5-bit index
	localparam logic [4:0] NC_RESET = (MAX_CLASSES > 31) ? 5'd31 : 5'(MAX_CLASSES);

	logic [4:0]        num_classes_q;
	aca_pkg::cmd_t     cmd;
	aca_pkg::status_t  status;
	logic              item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NC_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			num_classes_q <= pwdata[4:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = !paddr[2] ? {27'd0, num_classes_q} : 32'd0;

	assign item.ready = item_ready;

	aca_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	aca_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.num_classes         (num_classes_q),
		.in_operation        (item.operation),
		.in_class_index      (item.class_index),
		.in_true_label       (item.true_label),
		.in_value            (item.value),
		.in_last_class       (item.last_class),
		.res_valid           (result.valid),
		.res_ready           (result.ready),
		.res_kind            (result.result_kind),
		.res_predicted_class (result.predicted_class),
		.res_cell_count      (result.cell_count)
	);

endmodule

### test/aca_prediction_check.sv
// ----------------------------------------------------------------------------
// aca_prediction_check: result predictor and comparator
// Watches the item, result and register ports of the argmax confusion
// accumulator. Keeps its own copy of priors, running best and confusion
// counts, queues the answer each accepted item should produce, and compares
// every accepted result field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module aca_prediction_check #(
	parameter int         MAX_CLASSES  = 16,
	parameter int         COUNT_WIDTH  = 16,
	parameter logic [2:0] CLASSES_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	aca_in_if           item,
	aca_out_if          result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fault_count,
	output int          due_count
);

	localparam int SIDE = MAX_CLASSES + 1;
	localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

	typedef struct packed {
		logic        kind;
		logic [4:0]  cls;
		logic [15:0] cnt;
	} answer_t;

	logic [COUNT_WIDTH-1:0] tally [SIDE][SIDE];
	logic [31:0]            prior [SIDE];
	logic [63:0]            lead_product;
	logic [4:0]             lead_class;
	logic [4:0]             classes_used;
	answer_t                answers_due [$];
	int                     faults = 0;

	aca_pkg::op_t op;
	logic [4:0]  cls;
	logic [4:0]  lab;
	logic [31:0] val;
	logic [63:0] product;
	logic [15:0] count;
	answer_t     want;

	assign fault_count = faults;

	function automatic logic [15:0] low_count(logic [COUNT_WIDTH-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[15:0];
	endfunction

	function void zero_tally();
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				tally[r][c] = '0;
	endfunction

	function void compare_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			faults++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_tally();
			for (int i = 0; i < SIDE; i++)
				prior[i] = '0;
			lead_product = '0;
			lead_class   = '0;
			classes_used = 5'(MAX_CLASSES);
			answers_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == CLASSES_ADDR)
				classes_used = pwdata[4:0];

			if (item.valid && item.ready) begin
				op  = aca_pkg::op_t'(item.operation);
				cls = item.class_index;
				lab = item.true_label;
				val = item.value;
				case (op)
					aca_pkg::OP_SCORE: begin
						// class zero means no prediction, so it never competes
						if (cls >= 1 && cls <= classes_used && cls <= MAX_CLASSES) begin
							product = 64'(val) * 64'(prior[cls]);
							if (product > lead_product) begin
								lead_product = product;
								lead_class   = cls;
							end
						end
						if (item.last_class) begin
							count = '0;
							if (lab <= MAX_CLASSES) begin
								if (tally[lab][lead_class] != TALLY_MAX)
									tally[lab][lead_class] += 1'b1;
								count = low_count(tally[lab][lead_class]);
							end
							answers_due.push_back(
								answer_t'{aca_pkg::KIND_PRED, lead_class, count});
							lead_product = '0;
							lead_class   = '0;
						end
					end
					aca_pkg::OP_PRIOR: begin
						if (cls <= MAX_CLASSES)
							prior[cls] = val;
					end
					aca_pkg::OP_READ: begin
						count = '0;
						if (lab <= MAX_CLASSES && cls <= MAX_CLASSES)
							count = low_count(tally[lab][cls]);
						answers_due.push_back(answer_t'{aca_pkg::KIND_CELL, cls, count});
					end
					default: zero_tally();
				endcase
			end

			if (result.valid && result.ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected result: kind %0d class %0d count %0d",
						result.result_kind, result.predicted_class, result.cell_count);
					faults++;
				end else begin
					want = answers_due.pop_front();
					compare_field("result_kind", want.kind, result.result_kind);
					compare_field("predicted_class", want.cls, result.predicted_class);
					compare_field("cell_count", want.cnt, result.cell_count);
				end
			end
		end
		due_count = answers_due.size();
	end

endmodule

### test/tb_argmax_confusion_accumulator_core.sv
// ----------------------------------------------------------------------------
// tb_argmax_confusion_accumulator_core: testbench top
// Drives directed and random operation items with random gaps and result
// back-pressure, steps the class count register through its extremes while
// the block is idle, and gives the verdict from the failure count of the
// prediction checker.
// ----------------------------------------------------------------------------
module tb_argmax_confusion_accumulator_core;

	localparam int         MAX_CLASSES      = 16;
	localparam int         COUNT_WIDTH      = 16;
	localparam logic [2:0] ADDR_NUM_CLASSES = 3'd0;
	localparam int         SETTLE           = (MAX_CLASSES + 1) ** 2 + 16;
	localparam int         QUIET_LIMIT      = 4 * SETTLE + 400;
	localparam int         RANDOM_ITEMS     = 500;
	localparam int         PHASES           = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int   faults;
	int   due;
	int   sent = 0;
	bit   calm = 1'b0;
	logic [4:0] cur_classes = 5'(MAX_CLASSES);

	aca_in_if  item_ch ();
	aca_out_if result_ch ();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	argmax_confusion_accumulator_core #(
		.MAX_CLASSES(MAX_CLASSES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	aca_prediction_check #(
		.MAX_CLASSES(MAX_CLASSES),
		.COUNT_WIDTH(COUNT_WIDTH),
		.CLASSES_ADDR(ADDR_NUM_CLASSES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fault_count(faults),
		.due_count(due)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom();
		endcase
	endfunction

	// mostly rows and columns in range, now and then beyond the matrix
	function automatic logic [4:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return 5'($urandom_range(MAX_CLASSES + 1, 31));
		return 5'($urandom_range(0, MAX_CLASSES));
	endfunction

	task automatic send(aca_pkg::op_t op, logic [4:0] cls, logic [4:0] lab,
			logic [31:0] val, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid       = 1'b1;
		item_ch.operation   = op;
		item_ch.class_index = cls;
		item_ch.true_label  = lab;
		item_ch.value       = val;
		item_ch.last_class  = last;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		// skip items the block drops without effect
		if (!(op == aca_pkg::OP_SCORE && !last
				&& (cls == 0 || cls > cur_classes || cls > MAX_CLASSES))
				&& !(op == aca_pkg::OP_PRIOR && cls > MAX_CLASSES))
			sent++;
	endtask

	// hold the sender until every answer is back, then let a clear finish
	task automatic settle();
		item_ch.valid = 1'b0;
		wait (due == 0);
		@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_classes(logic [4:0] n);
		settle();
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = ADDR_NUM_CLASSES;
		pwdata  = 32'(n);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		cur_classes = n;
	endtask

	task automatic random_node();
		int parts;
		int c;
		logic [4:0] lab;
		parts = $urandom_range(1, 6);
		lab   = pick_index();
		c     = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < parts; i++) begin
			// interleave other operations inside a node now and then
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send(aca_pkg::OP_PRIOR, pick_index(), 5'($urandom()),
						rand_value(), 1'($urandom()));
				else
					send(aca_pkg::OP_READ, pick_index(), pick_index(),
						$urandom(), 1'($urandom()));
			end
			send(aca_pkg::OP_SCORE, 5'(c), lab, rand_value(), i == parts - 1);
			c = (c > 28) ? 31 : c + $urandom_range(1, 3);
		end
	endtask

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm) begin
				result_ch.ready = 1'b1;
			end else begin
				result_ch.ready = ($urandom_range(0, 2) != 0);
				hold = pick_gap();
			end
		end
	end

	initial begin
		int r;
		int goal;
		logic [4:0] phase_classes [PHASES];

		item_ch.valid       = 1'b0;
		item_ch.operation   = aca_pkg::OP_SCORE;
		item_ch.class_index = '0;
		item_ch.true_label  = '0;
		item_ch.value       = '0;
		item_ch.last_class  = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reads at reset, including rows and columns past the matrix
		send(aca_pkg::OP_READ, 5'd0, 5'd0, 32'd0, 1'b0);
		send(aca_pkg::OP_READ, 5'd16, 5'd16, '1, 1'b1);
		send(aca_pkg::OP_READ, 5'd31, 5'd17, 32'd0, 1'b0);
		// all priors zero: nothing beats zero, predict class 0
		send(aca_pkg::OP_SCORE, 5'd1, 5'd3, 32'd5, 1'b1);
		send(aca_pkg::OP_PRIOR, 5'd1, 5'd0, 32'h0001_0000, 1'b0);
		send(aca_pkg::OP_PRIOR, 5'd2, 5'd0, '1, 1'b0);
		send(aca_pkg::OP_PRIOR, 5'd16, 5'd0, '1, 1'b0);
		send(aca_pkg::OP_PRIOR, 5'd0, 5'd0, '1, 1'b0);
		send(aca_pkg::OP_PRIOR, 5'd31, 5'd0, 32'h1234_5678, 1'b0);
		// class 0 ignored; class 16 ties class 2 at full scale and loses
		send(aca_pkg::OP_SCORE, 5'd0, 5'd16, '1, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd1, 5'd16, 32'h0001_0000, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd2, 5'd16, '1, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd16, 5'd16, '1, 1'b1);
		// label out of range, finishing item on a class out of range
		send(aca_pkg::OP_SCORE, 5'd5, 5'd31, '1, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd31, 5'd31, '1, 1'b1);
		// read, prior write and clear in the middle of a node
		send(aca_pkg::OP_SCORE, 5'd1, 5'd0, 32'd1, 1'b0);
		send(aca_pkg::OP_READ, 5'd2, 5'd16, 32'd0, 1'b0);
		send(aca_pkg::OP_PRIOR, 5'd3, 5'd0, 32'h0002_0000, 1'b0);
		send(aca_pkg::OP_CLEAR, 5'd0, 5'd0, 32'd0, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd3, 5'd0, 32'd1, 1'b1);
		send(aca_pkg::OP_READ, 5'd3, 5'd0, 32'd0, 1'b0);
		send(aca_pkg::OP_READ, 5'd2, 5'd16, 32'd0, 1'b0);
		set_classes(5'd0);
		send(aca_pkg::OP_SCORE, 5'd2, 5'd5, '1, 1'b1);
		set_classes(5'd1);
		send(aca_pkg::OP_SCORE, 5'd1, 5'd4, 32'd7, 1'b0);
		send(aca_pkg::OP_SCORE, 5'd2, 5'd4, '1, 1'b1);

		phase_classes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'($urandom_range(2, 15)), 5'd16};
		sent = 0;
		goal = 0;
		for (int p = 0; p < PHASES; p++) begin
			set_classes(phase_classes[p]);
			calm = (p == 2);
			goal += RANDOM_ITEMS / PHASES;
			while (sent < goal) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					random_node();
				else if (r < 72)
					send(aca_pkg::OP_PRIOR, pick_index(), 5'($urandom()),
						rand_value(), 1'($urandom()));
				else if (r < 90)
					send(aca_pkg::OP_READ, pick_index(), pick_index(),
						$urandom(), 1'($urandom()));
				else if (r < 92)
					send(aca_pkg::OP_CLEAR, 5'($urandom()), 5'($urandom()),
						$urandom(), 1'($urandom()));
				else
					send(aca_pkg::OP_SCORE, 5'($urandom()), 5'($urandom()),
						$urandom(), 1'($urandom()));
			end
		end
		calm = 1'b0;

		item_ch.valid = 1'b0;
		wait (due == 0);
		repeat (SETTLE) @(posedge clk);
		if (faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
